// ===== rtl/ulprb_pkg.sv =====
// types, codes and helper functions shared by the uplink prb allocation pipeline
package ulprb_pkg;

    // configuration register indexes
    localparam logic CFG_CELL_PRB   = 1'b0;
    localparam logic CFG_HOP_OFFSET = 1'b1;

    // reset value of the cell width register
    localparam logic [6:0] CELL_PRB_RESET = 7'd50;

    // hop_kind result codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TYPE1 = 2'd1;
    localparam logic [1:0] KIND_TYPE2 = 2'd2;

    // hopping mode request codes, values five to seven are invalid
    typedef enum logic [2:0] {
        HOP_NONE    = 3'd0,
        HOP_TYPE2   = 3'd1,
        HOP_PLUS_Q  = 3'd2,
        HOP_MINUS_Q = 3'd3,
        HOP_HALF    = 3'd4
    } t_hop_sel;

    // pipeline layout
    localparam int RIV_W       = 14;
    localparam int MOD_W       = 8;
    localparam int BITS_PER_ST = 2;
    localparam int ST_IN       = 0;
    localparam int ST_DIV_LAST = ST_IN + RIV_W / BITS_PER_ST;
    localparam int ST_MIRROR   = ST_DIV_LAST + 1;
    localparam int ST_HOP      = ST_MIRROR + 1;
    localparam int ST_MOD_LAST = ST_HOP + MOD_W / BITS_PER_ST;
    localparam int ST_OUT      = ST_MOD_LAST + 1;
    localparam int NUM_ST      = ST_OUT + 1;

    // one request as it moves through the pipeline
    typedef struct packed {
        logic [RIV_W-1:0] dvd;
        logic [RIV_W-1:0] quo;
        logic [6:0]       rem;
        t_hop_sel         mode;
        logic [2:0]       dmrs;
        logic [6:0]       len;
        logic [6:0]       s0;
        logic [7:0]       s1;
        logic             len_ok;
        logic             bad;
        logic [1:0]       kind;
        logic             do_mod;
        logic [MOD_W-1:0] mdvd;
        logic [6:0]       mrem;
        logic [6:0]       band;
    } t_item;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [7:0] div_step(logic [6:0] rem, logic dbit, logic [6:0] dvs);
        logic [7:0] t;
        t = {rem, dbit};
        if (t >= {1'b0, dvs}) begin
            div_step = {1'b1, 7'(t - {1'b0, dvs})};
        end else begin
            div_step = {1'b0, t[6:0]};
        end
    endfunction

endpackage

// ===== rtl/ul_prb_allocation_type1_hop.sv =====
// uplink prb allocation decoder with type-1 frequency hopping, fully pipelined
//
// Decodes one uplink grant per request: the resource indication value is split
// into quotient and remainder by the effective cell width (cell_prb_count
// clamped to MAX_PRB), mirrored where start plus length runs past the cell,
// and the slot-one start is then derived for the selected hopping mode inside
// the hopping band. A new request is taken every clock cycle while the
// pipeline is not stalled by back-pressure; each request passes 15 register
// stages: the input register, the 14-bit restoring divider (two quotient
// bits per stage, seven stages), the mirror and hop stages, the 8-bit band
// modulo (four stages) and the check stage. Valid bits travel with each
// stage and empty stages close up under back-pressure, so requests are still
// taken while a finished result waits at the output register. The
// configuration port is a plain write port, register 0 is the cell width
// (reset 50) and register 1 the hopping offset (reset 0); it must only be
// written while no request is in flight.
module ul_prb_allocation_type1_hop #(
    parameter int MAX_PRB = 110
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    // grant request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [13:0] i_riv,
    input  logic [2:0]  i_hop_sel,
    input  logic [2:0]  i_dmrs_shift_in,
    // allocation result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_start_prb_slot0,
    output logic [6:0] o_start_prb_slot1,
    output logic [6:0] o_length_prb,
    output logic [1:0] o_hop_kind,
    output logic [2:0] o_dmrs_shift,
    output logic       o_status
);
    import ulprb_pkg::*;

    localparam logic [6:0] MaxPrb = 7'(MAX_PRB);

    // configuration registers
    logic [6:0] r_cell;
    logic [6:0] r_ho;
    logic [6:0] w_n;

    // pipeline stage registers and their valid bits
    t_item             r_st [NUM_ST];
    t_item             n_st [NUM_ST];
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] n_vld;
    logic [NUM_ST-1:0] w_en;

    // two division steps of riv by the cell width
    function automatic t_item f_div(t_item a, logic [6:0] n);
        t_item      o;
        logic [7:0] t;
        o = a;
        for (int b = 0; b < BITS_PER_ST; b++) begin
            t     = div_step(o.rem, o.dvd[RIV_W-1], n);
            o.quo = {o.quo[RIV_W-2:0], t[7]};
            o.rem = t[6:0];
            o.dvd = {o.dvd[RIV_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // length and start, mirrored when the allocation wraps past the cell
    function automatic t_item f_mirror(t_item a, logic [6:0] n);
        t_item             o;
        logic signed [16:0] l;
        logic signed [16:0] s;
        logic signed [16:0] nn;
        o  = a;
        nn = $signed({10'b0, n});
        l  = $signed({3'b0, a.quo}) + 17'sd1;
        s  = $signed({10'b0, a.rem});
        if (l + s > nn) begin
            l = nn + 17'sd2 - l;
            s = nn - 17'sd1 - s;
        end
        o.len_ok = (n != 7'd0) && (l >= 17'sd1) && (l <= nn);
        o.bad    = !o.len_ok;
        o.len    = o.len_ok ? l[6:0] : 7'd0;
        o.s0     = (n == 7'd0) ? 7'd0 : s[6:0];
        return o;
    endfunction

    // hopping band, offset check and slot-one preparation
    function automatic t_item f_hop(t_item a, logic [6:0] n, logic [6:0] ho);
        t_item             o;
        logic [7:0]        ho_r;
        logic [6:0]        half_ho;
        logic signed [8:0] band;
        logic [6:0]        b7;
        logic [6:0]        quarter;
        o       = a;
        ho_r    = {1'b0, ho} + {7'b0, ho[0]};
        half_ho = ho_r[7:1];
        band    = $signed({2'b0, n}) - $signed({1'b0, ho_r}) - $signed({8'b0, n[0]});
        b7      = band[6:0];
        quarter = b7 >> 2;
        o.s1     = {1'b0, a.s0};
        o.do_mod = 1'b0;
        o.mdvd   = '0;
        o.mrem   = '0;
        o.band   = b7;
        o.kind   = KIND_NONE;
        unique case (a.mode)
            HOP_NONE: begin
                o.kind = KIND_NONE;
            end
            HOP_TYPE2: begin
                o.kind = KIND_TYPE2;
            end
            HOP_PLUS_Q, HOP_MINUS_Q, HOP_HALF: begin
                o.kind = KIND_TYPE1;
                if (a.s0 < half_ho) begin
                    // offset error
                    o.bad  = 1'b1;
                    o.dmrs = 3'd0;
                end else if (band <= 9'sd0) begin
                    // empty hopping band
                    o.bad = 1'b1;
                end else if (a.mode == HOP_PLUS_Q) begin
                    o.do_mod = 1'b1;
                    o.mdvd   = {1'b0, quarter} + {1'b0, a.s0};
                end else if (a.mode == HOP_MINUS_Q) begin
                    if (a.s0 < quarter) begin
                        o.s1 = {1'b0, b7} + {1'b0, a.s0} - {1'b0, quarter};
                    end else begin
                        o.s1 = {1'b0, a.s0} - {1'b0, quarter};
                    end
                end else begin
                    o.do_mod = 1'b1;
                    o.mdvd   = {1'b0, b7 >> 1} + {1'b0, a.s0};
                end
            end
            default: begin
                o.bad = 1'b1;
            end
        endcase
        return o;
    endfunction

    // two steps of the band modulo
    function automatic t_item f_mod(t_item a);
        t_item      o;
        logic [7:0] t;
        o = a;
        for (int b = 0; b < BITS_PER_ST; b++) begin
            t      = div_step(o.mrem, o.mdvd[MOD_W-1], o.band);
            o.mrem = t[6:0];
            o.mdvd = {o.mdvd[MOD_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // final slot-one select and cell overflow check
    function automatic t_item f_out(t_item a, logic [6:0] n);
        t_item      o;
        logic [7:0] s1f;
        o   = a;
        s1f = a.do_mod ? {1'b0, a.mrem} : a.s1;
        o.s1 = s1f;
        if (a.len_ok && (({2'b0, a.s0} + {2'b0, a.len} > {2'b0, n})
                || ({1'b0, s1f} + {2'b0, a.len} > {2'b0, n}))) begin
            o.bad = 1'b1;
        end
        return o;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= CELL_PRB_RESET;
            r_ho   <= 7'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_PRB:   r_cell <= i_cfg_data;
                CFG_HOP_OFFSET: r_ho   <= i_cfg_data;
                default:        r_cell <= r_cell;
            endcase
        end
    end

    // effective cell width, clamped
    assign w_n = (r_cell > MaxPrb) ? MaxPrb : r_cell;

    // stage enables: a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[NUM_ST-1] = !r_vld[NUM_ST-1] || i_ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = i_valid;
        for (int k = 1; k < NUM_ST; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    // stage datapath
    always_comb begin
        n_st[ST_IN]      = '0;
        n_st[ST_IN].dvd  = i_riv;
        n_st[ST_IN].mode = t_hop_sel'(i_hop_sel);
        n_st[ST_IN].dmrs = i_dmrs_shift_in;
        for (int k = ST_IN + 1; k <= ST_DIV_LAST; k++) begin
            n_st[k] = f_div(r_st[k-1], w_n);
        end
        n_st[ST_MIRROR] = f_mirror(r_st[ST_DIV_LAST], w_n);
        n_st[ST_HOP]    = f_hop(r_st[ST_MIRROR], w_n, r_ho);
        for (int k = ST_HOP + 1; k <= ST_MOD_LAST; k++) begin
            n_st[k] = f_mod(r_st[k-1]);
        end
        n_st[ST_OUT] = f_out(r_st[ST_MOD_LAST], w_n);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_ST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_ST; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // ports, no request is taken while reset is held
    assign o_ready           = i_rst_n && w_en[ST_IN];
    assign o_valid           = r_vld[ST_OUT];
    assign o_start_prb_slot0 = r_st[ST_OUT].s0;
    assign o_start_prb_slot1 = r_st[ST_OUT].s1[6:0];
    assign o_length_prb      = r_st[ST_OUT].len;
    assign o_hop_kind        = r_st[ST_OUT].kind;
    assign o_dmrs_shift      = r_st[ST_OUT].dmrs;
    assign o_status          = r_st[ST_OUT].bad;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the uplink prb allocation decoder with type-1 hopping
module tb;
    import ulprb_pkg::*;

    localparam int MAX_PRB      = 110;
    localparam int LIMIT_CYCLES = 200000;
    // drain margin after the last result
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_MAX   = 10;

    // hopping mode values outside the defined set
    localparam logic [2:0] HOP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] HOP_UNKNOWN_LAST  = 3'd7;

    // one allocation result as seen on the output ports
    typedef struct packed {
        logic [6:0] slot0;
        logic [6:0] slot1;
        logic [6:0] length;
        logic [1:0] kind;
        logic [2:0] shift;
        logic       status;
    } t_alloc;

    // clock, reset and every block input start at known values
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_idx       = CFG_CELL_PRB;
    logic [6:0]  i_cfg_data      = '0;
    logic        i_valid         = 1'b0;
    logic [13:0] i_riv           = '0;
    logic [2:0]  i_hop_sel       = HOP_NONE;
    logic [2:0]  i_dmrs_shift_in = '0;
    logic        i_ready         = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_start_prb_slot0;
    logic [6:0]  o_start_prb_slot1;
    logic [6:0]  o_length_prb;
    logic [1:0]  o_hop_kind;
    logic [2:0]  o_dmrs_shift;
    logic        o_status;

    // shadow copy of the configuration registers
    logic [6:0]  cell_prb_cfg   = CELL_PRB_RESET;
    logic [6:0]  hop_offset_cfg = 7'd0;

    // expected allocations, oldest first
    t_alloc      pending_allocs[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    // idle percentages for request and result sides
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int          rx_hold        = 0;

    ul_prb_allocation_type1_hop #(
        .MAX_PRB(MAX_PRB)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_riv             (i_riv),
        .i_hop_sel         (i_hop_sel),
        .i_dmrs_shift_in   (i_dmrs_shift_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_start_prb_slot0 (o_start_prb_slot0),
        .o_start_prb_slot1 (o_start_prb_slot1),
        .o_length_prb      (o_length_prb),
        .o_hop_kind        (o_hop_kind),
        .o_dmrs_shift      (o_dmrs_shift),
        .o_status          (o_status)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off while rx_hold runs down
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // decode one grant against the current shadow configuration
    function automatic t_alloc predict_alloc(input logic [13:0] riv, input logic [2:0] mode,
                                             input logic [2:0] dmrs);
        t_alloc     res;
        int         n;
        int         ho;
        int         rv;
        int         len;
        int         s0;
        int         s1;
        int         band;
        bit         bad;
        bit         len_ok;
        logic [1:0] kind;
        logic [2:0] shift;
        n      = cell_prb_cfg;
        ho     = hop_offset_cfg;
        rv     = riv;
        len    = 0;
        s0     = 0;
        band   = 0;
        bad    = 1'b0;
        len_ok = 1'b0;
        kind   = KIND_NONE;
        shift  = dmrs;
        // cell wider than the block supports is clamped
        if (n > MAX_PRB) begin
            n = MAX_PRB;
        end
        if (n == 0) begin
            bad = 1'b1;
        end else begin
            len = rv / n + 1;
            s0  = rv % n;
            // allocation runs past the cell edge, so it is the mirrored form
            if (len + s0 > n) begin
                len = n + 2 - len;
                s0  = n - 1 - s0;
            end
            len_ok = (len >= 1) && (len <= n);
            if (!len_ok) begin
                bad = 1'b1;
                len = 0;
            end
        end
        s1 = s0;
        // odd offsets round up to even
        if (ho % 2 != 0) begin
            ho = ho + 1;
        end
        case (mode)
            HOP_NONE: begin
                kind = KIND_NONE;
            end
            HOP_TYPE2: begin
                kind = KIND_TYPE2;
            end
            HOP_PLUS_Q, HOP_MINUS_Q, HOP_HALF: begin
                kind = KIND_TYPE1;
                band = n - ho - (n % 2);
                if (s0 < ho / 2) begin
                    // start below half the offset: shift cleared
                    bad   = 1'b1;
                    shift = '0;
                end else if (band <= 0) begin
                    // empty hopping band, no modulo taken
                    bad = 1'b1;
                end else if (mode == HOP_PLUS_Q) begin
                    s1 = (band / 4 + s0) % band;
                end else if (mode == HOP_MINUS_Q) begin
                    s1 = (s0 < band / 4) ? (band + s0 - band / 4) : (s0 - band / 4);
                end else begin
                    s1 = (band / 2 + s0) % band;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        // either slot running past the cell width
        if (len_ok && (s0 + len > n || s1 + len > n)) begin
            bad = 1'b1;
        end
        res.slot0  = 7'(s0);
        res.slot1  = 7'(s1);
        res.length = 7'(len);
        res.kind   = kind;
        res.shift  = shift;
        res.status = bad;
        return res;
    endfunction

    // result checker: each accepted allocation against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_alloc got;
        t_alloc want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_start_prb_slot0, o_start_prb_slot1, o_length_prb, o_hop_kind,
                    o_dmrs_shift, o_status};
            if (pending_allocs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result s0=%0d s1=%0d len=%0d kind=%0d dmrs=%0d st=%0d",
                             got.slot0, got.slot1, got.length, got.kind, got.shift,
                             got.status);
                end
            end else begin
                want = pending_allocs.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch exp s0=%0d s1=%0d len=%0d kind=%0d dmrs=%0d st=%0d",
                                 want.slot0, want.slot1, want.length, want.kind,
                                 want.shift, want.status);
                        $display("         got s0=%0d s1=%0d len=%0d kind=%0d dmrs=%0d st=%0d",
                                 got.slot0, got.slot1, got.length, got.kind, got.shift,
                                 got.status);
                    end
                end
            end
        end
    end

    // offer one request, with a random idle gap first, and log its expectation
    task automatic send_request(input logic [13:0] riv, input logic [2:0] mode,
                                input logic [2:0] dmrs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_riv           <= riv;
        i_hop_sel       <= mode;
        i_dmrs_shift_in <= dmrs;
        do @(posedge i_clk); while (!o_ready);
        pending_allocs.push_back(predict_alloc(riv, mode, dmrs));
    endtask

    // drop valid and wait until every expected result has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_allocs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // register write, only with the pipeline empty
    task automatic write_reg(input logic idx, input logic [6:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CELL_PRB:   cell_prb_cfg   = data;
            CFG_HOP_OFFSET: hop_offset_cfg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // idle settings change away from the clock edge
    task automatic set_idling(input int send_pct, input int recv_pct);
        wait_drained();
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(posedge i_clk);
    endtask

    // random cell width and offset, extremes included
    task automatic random_config();
        int pick;
        int cells;
        logic [6:0] offset;
        pick = $urandom_range(9);
        case (pick)
            0:       cells = 6;
            1:       cells = MAX_PRB;
            2:       cells = $urandom_range(127, MAX_PRB + 1);
            default: cells = $urandom_range(MAX_PRB, 6);
        endcase
        pick = $urandom_range(9);
        if (pick < 4) begin
            offset = 7'd0;
        end else if (pick == 4) begin
            offset = 7'd127;
        end else if (pick < 8) begin
            offset = 7'($urandom_range(cells / 3));
        end else begin
            offset = 7'($urandom_range(127));
        end
        write_reg(CFG_CELL_PRB, 7'(cells));
        write_reg(CFG_HOP_OFFSET, offset);
    endtask

    // mostly decodable grants for the current cell, some raw 14-bit values
    task automatic random_request();
        int         cells;
        logic [13:0] riv;
        logic [2:0]  mode;
        cells = (cell_prb_cfg > MAX_PRB) ? MAX_PRB : cell_prb_cfg;
        if (cells > 0 && $urandom_range(99) < 75) begin
            riv = 14'($urandom_range(cells * cells - 1));
        end else begin
            riv = 14'($urandom);
        end
        if ($urandom_range(9) == 0) begin
            mode = 3'($urandom_range(HOP_UNKNOWN_LAST, HOP_UNKNOWN_FIRST));
        end else begin
            mode = 3'($urandom_range(HOP_HALF, HOP_NONE));
        end
        send_request(riv, mode, 3'($urandom));
    endtask

    // reset configuration, field extremes and every hop mode
    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_request(14'd0,     HOP_NONE,          3'd0);
        send_request(14'h3FFF,  HOP_TYPE2,         3'd7);
        send_request(14'd49,    HOP_NONE,          3'd5);
        // largest riv for the cell, decodes through the mirror
        send_request(14'd2499,  HOP_NONE,          3'd1);
        send_request(14'd1234,  HOP_PLUS_Q,        3'd2);
        send_request(14'd1234,  HOP_MINUS_Q,       3'd3);
        // minus quarter wrapping round the band
        send_request(14'd3,     HOP_MINUS_Q,       3'd4);
        send_request(14'd1234,  HOP_HALF,          3'd6);
        send_request(14'h2AAA,  HOP_HALF,          3'd5);
        send_request(14'd7,     HOP_UNKNOWN_FIRST, 3'd1);
        send_request(14'h1555,  HOP_UNKNOWN_LAST,  3'd2);
    endtask

    // each error path but the unknown hop mode, and the width clamp
    task automatic test_special_cases();
        // empty cell
        write_reg(CFG_CELL_PRB, 7'd0);
        send_request(14'd5,     HOP_PLUS_Q,  3'd3);
        // cell wider than supported
        write_reg(CFG_CELL_PRB, 7'd127);
        send_request(14'h3FFF,  HOP_HALF,    3'd5);
        send_request(14'd109,   HOP_NONE,    3'd2);
        // odd offset rounds up to eight: start below half of it, then slot one overflow
        write_reg(CFG_CELL_PRB, 7'd50);
        write_reg(CFG_HOP_OFFSET, 7'd7);
        send_request(14'd2,     HOP_PLUS_Q,  3'd6);
        send_request(14'd1955,  HOP_HALF,    3'd4);
        send_request(14'd10,    HOP_MINUS_Q, 3'd1);
        // offset fills the cell: zero band, then a length that cannot decode
        write_reg(CFG_CELL_PRB, 7'd6);
        write_reg(CFG_HOP_OFFSET, 7'd6);
        send_request(14'd3,     HOP_PLUS_Q,  3'd7);
        send_request(14'h3FFF,  HOP_NONE,    3'd3);
        // largest offset
        write_reg(CFG_CELL_PRB, 7'd110);
        write_reg(CFG_HOP_OFFSET, 7'd127);
        send_request(14'd100,   HOP_HALF,    3'd6);
    endtask

    // random grants under each idling mix, configuration changed between blocks
    task automatic test_random_traffic();
        int send_pcts[4];
        int recv_pcts[4];
        send_pcts = '{0, 45, 0, 27};
        recv_pcts = '{0, 0, 45, 27};
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(send_pcts[ph], recv_pcts[ph]);
            for (int blk = 0; blk < 4; blk++) begin
                random_config();
                repeat (50) random_request();
            end
        end
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input
    task automatic test_output_hold_off();
        set_idling(0, 0);
        random_config();
        @(negedge i_clk);
        rx_hold = 300;
        @(posedge i_clk);
        repeat (80) random_request();
        // sender waits for every result before carrying on
        wait_drained();
        set_idling(27, 27);
        repeat (20) random_request();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_cases();
        test_random_traffic();
        test_output_hold_off();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_allocs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
